// File: design/tcce_pkg.sv
// Shared types, codes and widths for the text console cursor engine.
package tcce_pkg;

  localparam int COLS_DEF = 53;
  localparam int ROWS_DEF = 24;
  localparam int Q_DEPTH  = 2;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 6;
  localparam int CELL_W  = CHAR_W + COLOR_W;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'h20;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

  typedef enum logic [2:0] {
    K_PUT,
    K_BACK,
    K_NEWLINE,
    K_READ,
    K_BAD,
    K_CLEAR,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SWEEP,
    S_DONE
  } state_t;

endpackage

// File: design/tcce_front.sv
// Front end: accepts input words and classifies them into console commands.
module tcce_front #(
  parameter int COLS = tcce_pkg::COLS_DEF,
  parameter int ROWS = tcce_pkg::ROWS_DEF
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcce_pkg::OP_W-1:0]   in_opcode,
  input  logic [tcce_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tcce_pkg::ROW_W-1:0]  in_read_row,
  input  logic [tcce_pkg::COL_W-1:0]  in_read_col,
  input  logic                        q_full,
  input  logic                        init_busy,
  output logic                        q_push,
  output tcce_pkg::cmd_t              q_cmd
);
  import tcce_pkg::*;

  logic bad_addr;

  assign bad_addr = ({1'b0, in_read_row} >= (ROW_W + 1)'(ROWS)) ||
                    ({1'b0, in_read_col} >= (COL_W + 1)'(COLS));

  assign in_stall = q_full || init_busy;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_cmd.ch  = in_char_code;
    q_cmd.row = in_read_row;
    q_cmd.col = in_read_col;
    unique case (in_opcode)
      OP_PUT: begin
        if (in_char_code == CH_BACKSPACE) begin
          q_cmd.kind = K_BACK;
        end else if (in_char_code == CH_NEWLINE) begin
          q_cmd.kind = K_NEWLINE;
        end else begin
          q_cmd.kind = K_PUT;
        end
      end
      OP_READ:  q_cmd.kind = bad_addr ? K_BAD : K_READ;
      OP_CLEAR: q_cmd.kind = K_CLEAR;
      default:  q_cmd.kind = K_NOP;
    endcase
  end

endmodule

// File: design/tcce_queue.sv
// Short command queue between the front end and the back end.
module tcce_queue #(
  parameter int DEPTH = tcce_pkg::Q_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcce_pkg::cmd_t din,
  output logic           full,
  output logic           valid,
  output tcce_pkg::cmd_t dout,
  input  logic           pop
);
  import tcce_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (!rst_n) pop |-> valid;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("queue popped while empty");

  property p_no_push_full;
    @(posedge clk) disable iff (!rst_n) push |-> (!full || pop);
  endproperty
  a_no_push_full: assert property (p_no_push_full) else $error("queue pushed while full");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue count out of range");

endmodule

// File: design/tcce_back.sv
// Back end: executes console commands against the cell memory and drives results.
module tcce_back #(
  parameter int COLS = tcce_pkg::COLS_DEF,
  parameter int ROWS = tcce_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  tcce_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  input  logic [tcce_pkg::COLOR_W-1:0] text_color,
  output logic                         init_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcce_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [tcce_pkg::COLOR_W-1:0] out_cell_color,
  output logic [tcce_pkg::ROW_W-1:0]   out_cursor_line,
  output logic [tcce_pkg::COL_W-1:0]   out_cursor_position,
  output logic                         out_scrolled,
  output logic                         out_bad_address
);
  import tcce_pkg::*;

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);

  function automatic logic [ROW_W-1:0] stored_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] shown);
    logic [ROW_W:0] sum;
    sum = {1'b0, top} + {1'b0, shown};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] srow,
                                              input logic [COL_W-1:0] col);
    return AW'(int'(srow) * COLS + int'(col));
  endfunction

  logic [CELL_W-1:0]  cell_mem_r [DEPTH];
  logic [CELL_W-1:0]  rd_data_r;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt;
  logic [COLOR_W-1:0] fill_color_r, fill_color_nxt;
  logic [AW-1:0]      sweep_addr_r, sweep_addr_nxt;
  logic [LW-1:0]      sweep_left_r, sweep_left_nxt;
  logic [CHAR_W-1:0]  res_char_r, res_char_nxt;
  logic [COLOR_W-1:0] res_color_r, res_color_nxt;
  logic               res_scroll_r, res_scroll_nxt;
  logic               res_bad_r, res_bad_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [ROW_W-1:0]   out_line_r;
  logic [COL_W-1:0]   out_pos_r;
  logic               out_scroll_r;
  logic               out_bad_r;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic               out_free;
  logic               out_load;
  logic               at_bottom;
  logic               last_col;
  logic               row_advance;
  logic               do_scroll;
  logic               sweep_last;

  assign out_free    = !out_valid_r || !out_stall;
  assign at_bottom   = (cur_row_r == ROW_W'(ROWS - 1));
  assign last_col    = (cur_col_r == COL_W'(COLS - 1));
  assign row_advance = (q_cmd.kind == K_NEWLINE) || ((q_cmd.kind == K_PUT) && last_col);
  assign do_scroll   = row_advance && at_bottom;
  assign sweep_last  = (sweep_left_r == LW'(1));
  assign init_busy   = (state_r == S_INIT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind) inside
            K_READ:             state_nxt = S_READ;
            K_CLEAR:            state_nxt = S_SWEEP;
            K_PUT, K_NEWLINE:   state_nxt = do_scroll ? S_SWEEP : S_DONE;
            K_BACK, K_BAD, K_NOP: state_nxt = S_DONE;
            default:            state_nxt = S_DONE;
          endcase
        end
      end
      S_READ: state_nxt = S_DONE;
      S_SWEEP: begin
        if (sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    top_nxt        = top_r;
    fill_color_nxt = fill_color_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_left_nxt = sweep_left_r;
    res_char_nxt   = res_char_r;
    res_color_nxt  = res_color_r;
    res_scroll_nxt = res_scroll_r;
    res_bad_nxt    = res_bad_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = sweep_addr_r;
    mem_wdata      = {fill_color_r, CH_SPACE};
    mem_re         = 1'b0;
    mem_raddr      = cell_addr(stored_row(top_r, q_cmd.row), q_cmd.col);
    out_load       = 1'b0;
    unique case (state_r)
      S_INIT, S_SWEEP: begin
        mem_we         = 1'b1;
        sweep_addr_nxt = sweep_addr_r + AW'(1);
        sweep_left_nxt = sweep_left_r - LW'(1);
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          res_char_nxt   = '0;
          res_color_nxt  = '0;
          res_scroll_nxt = 1'b0;
          res_bad_nxt    = 1'b0;
          unique case (q_cmd.kind)
            K_PUT: begin
              mem_we      = 1'b1;
              mem_waddr   = cell_addr(stored_row(top_r, cur_row_r), cur_col_r);
              mem_wdata   = {text_color, q_cmd.ch};
              cur_col_nxt = last_col ? '0 : cur_col_r + COL_W'(1);
            end
            K_BACK: begin
              if (cur_col_r != '0) begin
                mem_we      = 1'b1;
                mem_waddr   = cell_addr(stored_row(top_r, cur_row_r), cur_col_r - COL_W'(1));
                mem_wdata   = {text_color, CH_SPACE};
                cur_col_nxt = cur_col_r - COL_W'(1);
              end
            end
            K_NEWLINE: cur_col_nxt = '0;
            K_READ:    mem_re = 1'b1;
            K_BAD:     res_bad_nxt = 1'b1;
            K_CLEAR: begin
              cur_row_nxt    = '0;
              cur_col_nxt    = '0;
              top_nxt        = '0;
              fill_color_nxt = text_color;
              sweep_addr_nxt = '0;
              sweep_left_nxt = LW'(DEPTH);
            end
            default: ;
          endcase
          if (row_advance) begin
            if (at_bottom) begin
              top_nxt        = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
              fill_color_nxt = text_color;
              sweep_addr_nxt = AW'(int'(top_r) * COLS);
              sweep_left_nxt = LW'(COLS);
              res_scroll_nxt = 1'b1;
            end else begin
              cur_row_nxt = cur_row_r + ROW_W'(1);
            end
          end
        end
      end
      S_READ: begin
        res_char_nxt  = rd_data_r[CHAR_W-1:0];
        res_color_nxt = rd_data_r[CELL_W-1:CHAR_W];
      end
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      top_r        <= '0;
      fill_color_r <= RESET_COLOR;
      sweep_addr_r <= '0;
      sweep_left_r <= LW'(DEPTH);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      top_r        <= top_nxt;
      fill_color_r <= fill_color_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_left_r <= sweep_left_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_char_r   <= res_char_nxt;
    res_color_r  <= res_color_nxt;
    res_scroll_r <= res_scroll_nxt;
    res_bad_r    <= res_bad_nxt;
    if (out_load) begin
      out_char_r   <= res_char_r;
      out_color_r  <= res_color_r;
      out_line_r   <= cur_row_r;
      out_pos_r    <= cur_col_r;
      out_scroll_r <= res_scroll_r;
      out_bad_r    <= res_bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= cell_mem_r[mem_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cell_char       = out_char_r;
  assign out_cell_color      = out_color_r;
  assign out_cursor_line     = out_line_r;
  assign out_cursor_position = out_pos_r;
  assign out_scrolled        = out_scroll_r;
  assign out_bad_address     = out_bad_r;

  property p_cursor_col_range;
    @(posedge clk) disable iff (!rst_n) {1'b0, cur_col_r} < (COL_W + 1)'(COLS);
  endproperty
  a_cursor_col_range: assert property (p_cursor_col_range) else $error("cursor column off screen");

  property p_cursor_row_range;
    @(posedge clk) disable iff (!rst_n)
      ({1'b0, cur_row_r} < (ROW_W + 1)'(ROWS)) && ({1'b0, top_r} < (ROW_W + 1)'(ROWS));
  endproperty
  a_cursor_row_range: assert property (p_cursor_row_range) else $error("row state off screen");

  property p_sweep_nonempty;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_INIT || state_r == S_SWEEP) |-> (sweep_left_r != '0);
  endproperty
  a_sweep_nonempty: assert property (p_sweep_nonempty) else $error("fill sweep ran empty");

  property p_pop_only_idle;
    @(posedge clk) disable iff (!rst_n) q_pop |-> (state_r == S_IDLE) && q_valid;
  endproperty
  a_pop_only_idle: assert property (p_pop_only_idle) else $error("command taken while busy");

endmodule

// File: design/text_console_cursor_engine_core.sv
// Top level of the text console cursor engine: color register, front end, queue, back end.
//
// The engine keeps a ROWS by COLS character screen and one cursor, the screen in a cell
// memory with one write port and one registered read port. After reset the whole memory
// is filled with spaces in color 7, one cell per cycle, and no input word is taken until
// that pass is done. A put, backspace, newline, unused opcode or out-of-range read goes
// from idle straight to the done state in the back end, and a valid read passes through
// a read state first, for the registered memory read port; a put or newline that scrolls
// also blanks the new bottom row, and a clear the whole screen, one write per cycle.
// A two-word queue lets the input side run ahead while the back end is busy, and the
// result is held in an output register so the next word proceeds while it waits.
module text_console_cursor_engine_core #(
  parameter int COLS = tcce_pkg::COLS_DEF,
  parameter int ROWS = tcce_pkg::ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tcce_pkg::COLOR_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcce_pkg::OP_W-1:0]    in_opcode,
  input  logic [tcce_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcce_pkg::ROW_W-1:0]   in_read_row,
  input  logic [tcce_pkg::COL_W-1:0]   in_read_col,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcce_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [tcce_pkg::COLOR_W-1:0] out_cell_color,
  output logic [tcce_pkg::ROW_W-1:0]   out_cursor_line,
  output logic [tcce_pkg::COL_W-1:0]   out_cursor_position,
  output logic                         out_scrolled,
  output logic                         out_bad_address
);
  import tcce_pkg::*;

  logic [COLOR_W-1:0] text_color_r;
  logic               q_full;
  logic               q_push;
  logic               q_valid;
  logic               q_pop;
  logic               init_busy;
  cmd_t               push_cmd;
  cmd_t               head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_we) begin
      text_color_r <= cfg_wdata;
    end
  end

  tcce_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_char_code(in_char_code),
    .in_read_row (in_read_row),
    .in_read_col (in_read_col),
    .q_full      (q_full),
    .init_busy   (init_busy),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  tcce_queue #(
    .DEPTH(Q_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (push_cmd),
    .full (q_full),
    .valid(q_valid),
    .dout (head_cmd),
    .pop  (q_pop)
  );

  tcce_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_cmd              (head_cmd),
    .q_pop              (q_pop),
    .text_color         (text_color_r),
    .init_busy          (init_busy),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_cell_char      (out_cell_char),
    .out_cell_color     (out_cell_color),
    .out_cursor_line    (out_cursor_line),
    .out_cursor_position(out_cursor_position),
    .out_scrolled       (out_scrolled),
    .out_bad_address    (out_bad_address)
  );

endmodule
